// ----- rtl/dbm_pkg.sv -----
`default_nettype none

package dbm_pkg;

    localparam int PROG_DEPTH       = 1024;
    localparam int ADDR_TABLE_DEPTH = 256;

    localparam int PROG_AW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int TAB_AW  = (ADDR_TABLE_DEPTH > 1) ? $clog2(ADDR_TABLE_DEPTH) : 1;

    localparam int CMD_W       = 2;
    localparam int IDX_W       = 10;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = 11;
    localparam int TAB_ENTRY_W = 10;
    localparam int DEST_W      = 16;
    localparam int OP_W        = 4;
    localparam int CMPC_W      = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam int CNT_W = (LEN_W > $clog2(PROG_DEPTH + 2)) ? LEN_W : $clog2(PROG_DEPTH + 2);
    localparam int PCW   = ((PROG_AW > DEST_W) ? PROG_AW : DEST_W) + 2;
    localparam int CMPW  = PCW + CNT_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_PROG = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TAB  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DATA      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_MATCHING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SUCCESS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL     = 2'd2;

    localparam logic [OP_W-1:0] OP_STOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_FETCH    = 4'd1;
    localparam logic [OP_W-1:0] OP_BRANCH   = 4'd2;
    localparam logic [OP_W-1:0] OP_INDIRECT = 4'd3;

    localparam logic [CMPC_W-1:0] CMP_LT = 3'd1;
    localparam logic [CMPC_W-1:0] CMP_LE = 3'd2;
    localparam logic [CMPC_W-1:0] CMP_GE = 3'd3;
    localparam logic [CMPC_W-1:0] CMP_GT = 3'd4;
    localparam logic [CMPC_W-1:0] CMP_EQ = 3'd5;
    localparam logic [CMPC_W-1:0] CMP_NE = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] data_byte;
    } dbm_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                accept_at_end;
        logic                fault;
    } dbm_out_t;

    typedef enum logic [2:0] {
        K_NONE      = 3'd0,
        K_LOAD_PROG = 3'd1,
        K_LOAD_TAB  = 3'd2,
        K_START     = 3'd3,
        K_DATA      = 3'd4
    } dbm_kind_t;

    typedef struct packed {
        dbm_kind_t         kind;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] data_byte;
    } dbm_op_t;

    function automatic logic cmp_holds(input logic [CMPC_W-1:0] code,
                                       input logic [BYTE_W-1:0] ch,
                                       input logic [BYTE_W-1:0] arg);
        logic r;
        case (code)
            CMP_LT:  r = (ch < arg);
            CMP_LE:  r = (ch <= arg);
            CMP_GE:  r = (ch >= arg);
            CMP_GT:  r = (ch > arg);
            CMP_EQ:  r = (ch == arg);
            CMP_NE:  r = (ch != arg);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dfa_bytecode_matcher_top.sv -----
// Byte-matching program engine with queue-style channels on both sides.
// Commands enter on in_item with push/full: load a program word, load an
// indirect-address table entry, start a match, or feed one data byte.
// Every command yields exactly one result on out_item, shown while empty is
// low and taken with pop: match status, the accept-at-end bit of the waiting
// fetch, and the fault flag of the current match.
// The program length register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
// A two-entry command queue takes a transfer every cycle until it fills.
// Loads and bytes fed while not matching go from the queue head through the
// done state to a registered result. A start or a data byte steps through the
// read and decode states for each executed instruction, the final fetch included
// (plus the table state for an indirect branch), as the program memory read in the loop is registered.
// Reset leaves the status at fail, clears the program counter and flags,
// and sets the program length to 1024; both memories are unknown until loaded.
// When the receiver stalls, the result holds on out_item, the engine waits
// with the next result, and the command queue fills and raises full.
`default_nettype none

module dfa_bytecode_matcher_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire dbm_pkg::dbm_in_t          in_item,
    output logic                           empty,
    input  wire logic                      pop,
    output dbm_pkg::dbm_out_t              out_item,
    input  wire logic                      cfg_wr_en,
    input  wire logic [dbm_pkg::LEN_W-1:0] cfg_wr_data
);

    logic [dbm_pkg::LEN_W-1:0] prog_length_reg;
    logic                      op_valid;
    logic                      op_ready;
    dbm_pkg::dbm_op_t          op;
    logic                      res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_length_reg <= dbm_pkg::LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            prog_length_reg <= cfg_wr_data;
        end
    end

    dbm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    dbm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op_ready    (op_ready),
        .op          (op),
        .prog_length (prog_length_reg),
        .res_valid   (res_valid),
        .pop         (pop),
        .res         (out_item)
    );

    assign empty = !res_valid;

    a_accept_only_matching: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_item.status != dbm_pkg::ST_MATCHING)) |-> !out_item.accept_at_end)
        else $error("accept_at_end set on a finished match");

    a_fault_means_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.fault) |-> (out_item.status == dbm_pkg::ST_FAIL))
        else $error("fault reported without fail status");

    a_full_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> op_valid)
        else $error("command queue full with nothing offered to the engine");

endmodule

`default_nettype wire

// ----- rtl/dbm_front.sv -----
`default_nettype none

module dbm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire dbm_pkg::dbm_in_t in_item,
    output logic                  op_valid,
    input  wire logic             op_ready,
    output dbm_pkg::dbm_op_t      op
);

    dbm_pkg::dbm_op_t              q_reg [dbm_pkg::Q_DEPTH];
    logic [dbm_pkg::Q_AW-1:0]      wptr_reg;
    logic [dbm_pkg::Q_AW-1:0]      rptr_reg;
    logic [dbm_pkg::Q_CW-1:0]      cnt_reg;
    dbm_pkg::dbm_op_t              cls;
    logic                          wr;
    logic                          rd;

    always_comb
    begin
        cls.addr      = in_item.index;
        cls.word      = in_item.word;
        cls.data_byte = in_item.data_byte;
        case (in_item.cmd)
            dbm_pkg::CMD_LOAD_PROG:
                cls.kind = (32'(in_item.index) < 32'(dbm_pkg::PROG_DEPTH)) ?
                           dbm_pkg::K_LOAD_PROG : dbm_pkg::K_NONE;
            dbm_pkg::CMD_LOAD_TAB:
                cls.kind = (32'(in_item.index) < 32'(dbm_pkg::ADDR_TABLE_DEPTH)) ?
                           dbm_pkg::K_LOAD_TAB : dbm_pkg::K_NONE;
            dbm_pkg::CMD_START:
                cls.kind = dbm_pkg::K_START;
            default:
                cls.kind = dbm_pkg::K_DATA;
        endcase
    end

    assign full     = (cnt_reg == dbm_pkg::Q_CW'(dbm_pkg::Q_DEPTH));
    assign op_valid = (cnt_reg != '0);
    assign op       = q_reg[rptr_reg];
    assign wr       = push && !full;
    assign rd       = op_valid && op_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dbm_engine.sv -----
`default_nettype none

module dbm_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        op_valid,
    output logic                             op_ready,
    input  wire dbm_pkg::dbm_op_t            op,
    input  wire logic [dbm_pkg::LEN_W-1:0]   prog_length,
    output logic                             res_valid,
    input  wire logic                        pop,
    output dbm_pkg::dbm_out_t                res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DEC  = 5'b00100,
        S_TAB  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    logic [dbm_pkg::WORD_W-1:0]      prog_mem_reg [dbm_pkg::PROG_DEPTH];
    logic [dbm_pkg::TAB_ENTRY_W-1:0] tab_mem_reg  [dbm_pkg::ADDR_TABLE_DEPTH];
    logic [dbm_pkg::WORD_W-1:0]      prog_rdata_reg;
    logic [dbm_pkg::TAB_ENTRY_W-1:0] tab_rdata_reg;

    state_t                          state_reg, state_next;
    logic [dbm_pkg::PCW-1:0]         pc_reg, pc_next;
    logic [dbm_pkg::CNT_W-1:0]       plain_reg, plain_next;
    logic [dbm_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [dbm_pkg::BYTE_W-1:0]      char_reg, char_next;
    logic [dbm_pkg::BYTE_W-1:0]      byte_reg, byte_next;
    logic                            have_byte_reg, have_byte_next;
    logic                            pend_reg, pend_next;
    logic                            fault_reg, fault_next;
    logic                            res_valid_reg, res_valid_next;
    dbm_pkg::dbm_out_t               res_reg, res_next;

    logic [dbm_pkg::CNT_W-1:0]       eff_len;
    logic [dbm_pkg::CNT_W-1:0]       plain_inc;
    logic [dbm_pkg::OP_W-1:0]        w_op;
    logic [dbm_pkg::CMPC_W-1:0]      w_cmp;
    logic                            w_end;
    logic [dbm_pkg::BYTE_W-1:0]      w_arg;
    logic [dbm_pkg::DEST_W-1:0]      w_dest;
    logic                            pc_bad;
    logic                            prog_we;
    logic                            tab_we;

    assign eff_len = (dbm_pkg::CNT_W'(prog_length) < dbm_pkg::CNT_W'(dbm_pkg::PROG_DEPTH)) ?
                     dbm_pkg::CNT_W'(prog_length) : dbm_pkg::CNT_W'(dbm_pkg::PROG_DEPTH);

    assign w_op   = prog_rdata_reg[31:28];
    assign w_cmp  = prog_rdata_reg[27:25];
    assign w_end  = prog_rdata_reg[24];
    assign w_arg  = prog_rdata_reg[23:16];
    assign w_dest = prog_rdata_reg[15:0];

    assign plain_inc = plain_reg + 1'b1;
    assign pc_bad    = pc_reg[dbm_pkg::PCW-1] ||
                       (dbm_pkg::CMPW'(pc_reg) >= dbm_pkg::CMPW'(eff_len));

    assign op_ready  = (state_reg == S_IDLE);
    assign prog_we   = op_ready && op_valid && (op.kind == dbm_pkg::K_LOAD_PROG);
    assign tab_we    = op_ready && op_valid && (op.kind == dbm_pkg::K_LOAD_TAB);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem_reg[dbm_pkg::PROG_AW'(op.addr)] <= op.word;
        end
        prog_rdata_reg <= prog_mem_reg[pc_reg[dbm_pkg::PROG_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem_reg[dbm_pkg::TAB_AW'(op.addr)] <= op.word[dbm_pkg::TAB_ENTRY_W-1:0];
        end
        tab_rdata_reg <= tab_mem_reg[w_dest[dbm_pkg::TAB_AW-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        plain_next     = plain_reg;
        status_next    = status_reg;
        char_next      = char_reg;
        byte_next      = byte_reg;
        have_byte_next = have_byte_reg;
        pend_next      = pend_reg;
        fault_next     = fault_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_DONE;
                    case (op.kind)
                        dbm_pkg::K_START:
                        begin
                            pc_next        = '0;
                            char_next      = '0;
                            pend_next      = 1'b0;
                            fault_next     = 1'b0;
                            status_next    = dbm_pkg::ST_MATCHING;
                            plain_next     = '0;
                            have_byte_next = 1'b0;
                            state_next     = S_READ;
                        end
                        dbm_pkg::K_DATA:
                        begin
                            if (status_reg == dbm_pkg::ST_MATCHING)
                            begin
                                plain_next     = '0;
                                have_byte_next = 1'b1;
                                byte_next      = op.data_byte;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (pc_bad)
                begin
                    fault_next  = 1'b1;
                    status_next = dbm_pkg::ST_FAIL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_READ;
                if (w_op == dbm_pkg::OP_FETCH)
                begin
                    if (!have_byte_reg)
                    begin
                        pend_next  = w_end;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        char_next      = byte_reg;
                        have_byte_next = 1'b0;
                        pc_next        = pc_reg + 1'b1;
                        plain_next     = '0;
                    end
                end
                else if (w_op > dbm_pkg::OP_INDIRECT)
                begin
                    fault_next  = 1'b1;
                    status_next = dbm_pkg::ST_FAIL;
                    state_next  = S_DONE;
                end
                else if (plain_inc > eff_len)
                begin
                    plain_next  = plain_inc;
                    fault_next  = 1'b1;
                    status_next = dbm_pkg::ST_FAIL;
                    state_next  = S_DONE;
                end
                else
                begin
                    plain_next = plain_inc;
                    if (!dbm_pkg::cmp_holds(w_cmp, char_reg, w_arg))
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    else if (w_op == dbm_pkg::OP_STOP)
                    begin
                        status_next = w_end ? dbm_pkg::ST_SUCCESS : dbm_pkg::ST_FAIL;
                        state_next  = S_DONE;
                    end
                    else if (w_op == dbm_pkg::OP_BRANCH)
                    begin
                        pc_next = pc_reg + {{(dbm_pkg::PCW - dbm_pkg::DEST_W){w_dest[15]}}, w_dest};
                    end
                    else if (32'(w_dest) >= 32'(dbm_pkg::ADDR_TABLE_DEPTH))
                    begin
                        fault_next  = 1'b1;
                        status_next = dbm_pkg::ST_FAIL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_TAB;
                    end
                end
            end
            S_TAB:
            begin
                pc_next    = dbm_pkg::PCW'(tab_rdata_reg);
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_valid_next        = 1'b1;
                    res_next.status       = status_reg;
                    res_next.accept_at_end = (status_reg == dbm_pkg::ST_MATCHING) && pend_reg;
                    res_next.fault        = fault_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            plain_reg     <= '0;
            status_reg    <= dbm_pkg::ST_FAIL;
            char_reg      <= '0;
            byte_reg      <= '0;
            have_byte_reg <= 1'b0;
            pend_reg      <= 1'b0;
            fault_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            plain_reg     <= plain_next;
            status_reg    <= status_next;
            char_reg      <= char_next;
            byte_reg      <= byte_next;
            have_byte_reg <= have_byte_next;
            pend_reg      <= pend_next;
            fault_reg     <= fault_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_dfa_bytecode_matcher_top.sv -----
`timescale 1ns / 100ps

module tb_dfa_bytecode_matcher_top;

    import dbm_pkg::*;

    localparam logic [CMPC_W-1:0] CMP_ALWAYS = 3'd0;
    localparam logic [CMPC_W-1:0] CMP_SEVEN  = 3'd7;
    localparam logic [OP_W-1:0]   OP_MAX     = 4'hf;

    localparam int          DRAIN_CYCLES = 16;
    localparam int          PHASE_ITEMS  = 195;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          NUM_PHASES   = 9;
    localparam int unsigned CYCLE_LIMIT  = 40_000_000;

    class match_scoreboard;
        logic [WORD_W-1:0]      code_mem [PROG_DEPTH];
        logic [TAB_ENTRY_W-1:0] jump_tab [ADDR_TABLE_DEPTH];
        logic [31:0]            pc;
        logic [STATUS_W-1:0]    match_state;
        logic [BYTE_W-1:0]      cur_char;
        logic                   pend_end;
        logic                   fault_seen;
        logic [LEN_W-1:0]       prog_len;
        dbm_out_t               expected_results [$];
        int                     errors;

        function new();
            pc          = '0;
            match_state = ST_FAIL;
            cur_char    = '0;
            pend_end    = 1'b0;
            fault_seen  = 1'b0;
            prog_len    = LEN_RESET;
            errors      = 0;
        endfunction

        function void take_length(logic [LEN_W-1:0] v);
            prog_len = v;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void trip_fault();
            fault_seen  = 1'b1;
            match_state = ST_FAIL;
        endfunction

        // Runs from pc until a fetch with no byte left, a stop, or a fault.
        function void execute_program(bit have_byte, logic [BYTE_W-1:0] b);
            logic [31:0]       lim;
            logic [31:0]       plain;
            logic [OP_W-1:0]   op;
            logic [CMPC_W-1:0] cmp;
            logic              fin;
            logic [BYTE_W-1:0] arg;
            logic [DEST_W-1:0] dest;
            logic              holds;
            lim   = (prog_len < PROG_DEPTH) ? 32'(prog_len) : 32'(PROG_DEPTH);
            plain = '0;
            forever
            begin
                if (pc >= lim)
                begin
                    trip_fault();
                    return;
                end
                {op, cmp, fin, arg, dest} = code_mem[pc[PROG_AW-1:0]];
                if (op == OP_FETCH)
                begin
                    if (!have_byte)
                    begin
                        pend_end = fin;
                        return;
                    end
                    cur_char  = b;
                    have_byte = 1'b0;
                    pc        = pc + 1;
                    plain     = '0;
                    continue;
                end
                if (op > OP_INDIRECT)
                begin
                    trip_fault();
                    return;
                end
                plain = plain + 1;
                if (plain > lim)
                begin
                    trip_fault();
                    return;
                end
                case (cmp)
                    CMP_LT:  holds = (cur_char < arg);
                    CMP_LE:  holds = (cur_char <= arg);
                    CMP_GE:  holds = (cur_char >= arg);
                    CMP_GT:  holds = (cur_char > arg);
                    CMP_EQ:  holds = (cur_char == arg);
                    CMP_NE:  holds = (cur_char != arg);
                    default: holds = 1'b1;
                endcase
                if (!holds)
                begin
                    pc = pc + 1;
                end
                else if (op == OP_STOP)
                begin
                    match_state = fin ? ST_SUCCESS : ST_FAIL;
                    return;
                end
                else if (op == OP_BRANCH)
                begin
                    pc = pc + {{16{dest[DEST_W-1]}}, dest};
                end
                else
                begin
                    if (dest >= ADDR_TABLE_DEPTH)
                    begin
                        trip_fault();
                        return;
                    end
                    pc = 32'(jump_tab[int'(dest)]);
                end
            end
        endfunction

        function void note_command(dbm_in_t it);
            dbm_out_t res;
            case (it.cmd)
                CMD_LOAD_PROG: code_mem[int'(it.index)] = it.word;
                CMD_LOAD_TAB:
                begin
                    if (it.index < ADDR_TABLE_DEPTH)
                        jump_tab[int'(it.index)] = it.word[TAB_ENTRY_W-1:0];
                end
                CMD_START:
                begin
                    pc          = '0;
                    cur_char    = '0;
                    pend_end    = 1'b0;
                    fault_seen  = 1'b0;
                    match_state = ST_MATCHING;
                    execute_program(1'b0, '0);
                end
                CMD_DATA:
                begin
                    if (match_state == ST_MATCHING)
                        execute_program(1'b1, it.data_byte);
                end
                default: ;
            endcase
            res.status        = match_state;
            res.accept_at_end = (match_state == ST_MATCHING) ? pend_end : 1'b0;
            res.fault         = fault_seen;
            expected_results.push_back(res);
        endfunction

        function void check_result(dbm_out_t got);
            dbm_out_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: expected no result, got status %0d accept %0b fault %0b",
                             $time, got.status, got.accept_at_end, got.fault);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.accept_at_end !== want.accept_at_end ||
                got.fault !== want.fault)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: expected st %0d acc %0b flt %0b, got st %0d acc %0b flt %0b",
                             $time, want.status, want.accept_at_end, want.fault,
                             got.status, got.accept_at_end, got.fault);
            end
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             push        = 1'b0;
    logic             full;
    dbm_in_t          in_item     = '0;
    logic             empty;
    logic             pop         = 1'b0;
    dbm_out_t         out_item;
    logic             cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    match_scoreboard sb = new;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_left = 0;
    int          sent      = 0;
    int unsigned cycles    = 0;

    dfa_bytecode_matcher_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] instr(input logic [OP_W-1:0] op,
                                                input logic [CMPC_W-1:0] cmp,
                                                input logic fin,
                                                input logic [BYTE_W-1:0] arg,
                                                input logic [DEST_W-1:0] dest);
        return {op, cmp, fin, arg, dest};
    endfunction

    // A target inside the loaded words, or now and then one outside the valid range.
    function automatic int pick_target(int p, int eff, bit for_table);
        if ($urandom_range(0, 15) != 0)
            return $urandom_range(0, p - 1);
        if (for_table)
            return (eff < PROG_DEPTH) ? $urandom_range(eff, PROG_DEPTH - 1)
                                      : $urandom_range(0, p - 1);
        if ($urandom_range(0, 1) != 0)
            return eff + $urandom_range(0, 200);
        return -int'($urandom_range(1, 40));
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] w, input logic [BYTE_W-1:0] b);
        dbm_in_t it;
        it.cmd       = c;
        it.index     = idx;
        it.word      = w;
        it.data_byte = b;
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_command(it);
        sent++;
    endtask

    task automatic set_length(input logic [LEN_W-1:0] v);
        push <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.take_length(v);
    endtask

    // Loads a small program and its table entries, starts a match and feeds bytes.
    // Every word the match can reach is loaded here, so nothing unwritten is read.
    task automatic run_episode(input int eff);
        int                p;
        int                n;
        int                i;
        logic [OP_W-1:0]   op;
        logic [CMPC_W-1:0] cmp;
        logic              fin;
        logic [BYTE_W-1:0] arg;
        logic [BYTE_W-1:0] b;
        logic [DEST_W-1:0] dest;
        logic [WORD_W-1:0] words [$];
        logic [BYTE_W-1:0] args [$];
        int                slots [$];
        int                tgts [$];
        p = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        if (p > eff)
            p = eff;
        for (i = 0; i < p; i++)
        begin
            cmp  = CMPC_W'($urandom_range(0, 7));
            fin  = ($urandom_range(0, 1) != 0);
            arg  = BYTE_W'($urandom);
            dest = DEST_W'($urandom);
            n    = $urandom_range(0, 99);
            if (n < 35)
            begin
                op = OP_FETCH;
            end
            else if (n < 60)
            begin
                op   = OP_BRANCH;
                dest = 16'(pick_target(p, eff, 1'b0) - i);
            end
            else if (n < 75)
            begin
                op = OP_INDIRECT;
                if ($urandom_range(0, 11) == 0)
                begin
                    dest = DEST_W'($urandom_range(ADDR_TABLE_DEPTH, 65535));
                end
                else
                begin
                    dest = DEST_W'($urandom_range(0, ADDR_TABLE_DEPTH - 1));
                    slots.push_back(int'(dest));
                    tgts.push_back(pick_target(p, eff, 1'b1));
                end
            end
            else if (n < 95)
            begin
                op = OP_STOP;
            end
            else
            begin
                op = OP_W'($urandom_range(OP_INDIRECT + 1, OP_MAX));
            end
            // The last word must not fall through into words that were never loaded.
            if (i == p - 1 && p < eff)
            begin
                op  = OP_STOP;
                cmp = ($urandom_range(0, 1) != 0) ? CMP_ALWAYS : CMP_SEVEN;
            end
            words.push_back(instr(op, cmp, fin, arg, dest));
            args.push_back(arg);
        end
        for (i = 0; i < p; i++)
            send_cmd(CMD_LOAD_PROG, 10'(i), words[i], 8'($urandom));
        for (i = 0; i < slots.size(); i++)
            send_cmd(CMD_LOAD_TAB, 10'(slots[i]), {22'($urandom), 10'(tgts[i])}, 8'($urandom));
        if ($urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 1) != 0 && p < PROG_DEPTH)
                send_cmd(CMD_LOAD_PROG, 10'($urandom_range(p, PROG_DEPTH - 1)), $urandom,
                         8'($urandom));
            else
                send_cmd(CMD_LOAD_TAB, 10'($urandom_range(ADDR_TABLE_DEPTH, 1023)), $urandom,
                         8'($urandom));
        end
        send_cmd(CMD_START, 10'($urandom), $urandom, 8'($urandom));
        n = $urandom_range(0, 12);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_cmd(CMD_START, 10'($urandom), $urandom, 8'($urandom));
            if ($urandom_range(0, 1) != 0)
                b = 8'(int'(args[$urandom_range(0, args.size() - 1)]) +
                       int'($urandom_range(0, 2)) - 1);
            else
                b = BYTE_W'($urandom);
            send_cmd(CMD_DATA, 10'($urandom), $urandom, b);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(out_item);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [WORD_W-1:0] demo [8];
        logic [LEN_W-1:0]  phase_len [NUM_PHASES];
        int                ph;
        int                i;
        int                eff;
        int                goal;
        demo[0] = instr(OP_FETCH,    CMP_ALWAYS, 1'b1, 8'h00, 16'h0000);
        demo[1] = instr(OP_BRANCH,   CMP_EQ,     1'b0, 8'h41, 16'h0003);
        demo[2] = instr(OP_INDIRECT, CMP_LT,     1'b0, 8'h30, 16'h00ff);
        demo[3] = instr(OP_STOP,     CMP_SEVEN,  1'b0, 8'hff, 16'hffff);
        demo[4] = instr(OP_FETCH,    CMP_ALWAYS, 1'b0, 8'h00, 16'h0000);
        demo[5] = instr(OP_BRANCH,   CMP_GE,     1'b0, 8'h80, 16'hfffb);
        demo[6] = instr(OP_INDIRECT, CMP_ALWAYS, 1'b0, 8'h00, 16'h0100);
        demo[7] = instr(OP_STOP,     CMP_ALWAYS, 1'b1, 8'h00, 16'h0000);
        phase_len = '{11'd1024, 11'd1, 11'd2047, 11'd3, 11'd64, 11'd1024, 11'd2, 11'd200,
                      11'd11};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 24;
        recv_idle = 76;
        set_length(11'd16);
        send_cmd(CMD_DATA, 10'd0, 32'd0, 8'hff);
        send_cmd(CMD_LOAD_TAB, 10'h3ff, 32'hffff_ffff, 8'h00);
        send_cmd(CMD_LOAD_TAB, 10'd255, 32'hffff_fc05, 8'h00);
        send_cmd(CMD_LOAD_PROG, 10'h3ff, 32'hffff_ffff, 8'hff);
        for (i = 0; i < 8; i++)
            send_cmd(CMD_LOAD_PROG, 10'(i), demo[i], 8'h00);
        send_cmd(CMD_START, 10'd0, 32'd0, 8'h00);
        send_cmd(CMD_DATA, 10'd0, 32'd0, 8'h41);
        send_cmd(CMD_DATA, 10'd0, 32'd0, 8'hff);
        send_cmd(CMD_DATA, 10'd0, 32'd0, 8'h20);
        send_cmd(CMD_DATA, 10'd0, 32'd0, 8'h00);
        send_cmd(CMD_START, 10'h3ff, 32'hffff_ffff, 8'hff);
        send_cmd(CMD_DATA, 10'd0, 32'd0, 8'h42);
        send_cmd(CMD_LOAD_PROG, 10'd0, instr(OP_MAX, CMP_ALWAYS, 1'b0, 8'h00, 16'h0000), 8'h00);
        send_cmd(CMD_START, 10'd0, 32'd0, 8'h00);
        send_cmd(CMD_LOAD_PROG, 10'd0, instr(OP_BRANCH, CMP_ALWAYS, 1'b0, 8'h00, 16'h8000),
                 8'h00);
        send_cmd(CMD_START, 10'd0, 32'd0, 8'h00);
        send_cmd(CMD_LOAD_PROG, 10'd0, instr(OP_BRANCH, CMP_ALWAYS, 1'b0, 8'h00, 16'h0000),
                 8'h00);
        send_cmd(CMD_START, 10'd0, 32'd0, 8'h00);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle = (ph < 3) ? 24 : (ph < 6) ? 76 : 0;
            recv_idle = (ph < 3) ? 76 : (ph < 6) ? 24 : 0;
            set_length(phase_len[ph]);
            if (ph == 6)
                hold_left = HOLD_CYCLES;
            eff  = (phase_len[ph] < PROG_DEPTH) ? int'(phase_len[ph]) : PROG_DEPTH;
            goal = sent + PHASE_ITEMS;
            while (sent < goal)
                run_episode(eff);
        end

        push <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dbm_pkg.sv
rtl/dbm_front.sv
rtl/dbm_engine.sv
rtl/dfa_bytecode_matcher_top.sv
tb/sv/tb_dfa_bytecode_matcher_top.sv
